// ===== hdl/tcw_pkg.sv =====
// ============================================================================
// tcw_pkg - shared definitions for the text console writer
// Input mode and character codes, the internal command set passed from the
// front end to the back end, and the fixed field widths of the channels.
// ============================================================================
package tcw_pkg;

    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CELL_W = 16;

    localparam logic [1:0] MODE_PUT   = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_RETURN  = 8'h0D;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    localparam logic [7:0] ATTR_RESET = 8'h0F;
    localparam logic [1:0] TAB_MASK   = 2'b11;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_PUT,
        OP_NEWLINE,
        OP_RETURN,
        OP_TAB,
        OP_CLEAR,
        OP_READ
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [7:0]       ch;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_cmd;

endpackage

// ===== hdl/tcw_chan_if.sv =====
// ============================================================================
// tcw_chan_if - valid/ready channels of the text console writer
// tcw_in_if carries one console request, tcw_out_if one result.
// ============================================================================
interface tcw_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] character_code;
    logic [4:0] read_row;
    logic [6:0] read_column;

    modport source (output valid, mode, character_code, read_row, read_column,
                    input ready);
    modport sink   (input valid, mode, character_code, read_row, read_column,
                    output ready);
endinterface

interface tcw_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] cell_data;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_column;
    logic        scrolled;

    modport source (output valid, cell_data, cursor_row, cursor_column, scrolled,
                    input ready);
    modport sink   (input valid, cell_data, cursor_row, cursor_column, scrolled,
                    output ready);
endinterface

// ===== hdl/tcw_front.sv =====
// ============================================================================
// tcw_front - request classifier
// Accepts requests and turns each into one back-end command: printable
// character, newline, carriage return, tab, clear, read, or no operation.
// ============================================================================
module tcw_front
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic    i_enable,
    input  logic    i_full,
    tcw_in_if.sink  i_in,
    output logic    o_push,
    output t_cmd    o_cmd
);

    logic in_range;

    assign i_in.ready = i_enable && !i_full;
    assign o_push     = i_in.valid && i_in.ready;

    // A read outside the screen returns zero, exactly as an unused mode does.
    assign in_range = (int'(i_in.read_row) < ROWS) && (int'(i_in.read_column) < COLUMNS);

    always_comb begin
        o_cmd.ch  = i_in.character_code;
        o_cmd.row = i_in.read_row;
        o_cmd.col = i_in.read_column;
        unique case (i_in.mode)
            MODE_PUT: begin
                unique case (i_in.character_code)
                    CHAR_NEWLINE: o_cmd.op = OP_NEWLINE;
                    CHAR_RETURN:  o_cmd.op = OP_RETURN;
                    CHAR_TAB:     o_cmd.op = OP_TAB;
                    default:      o_cmd.op = OP_PUT;
                endcase
            end
            MODE_CLEAR: o_cmd.op = OP_CLEAR;
            MODE_READ:  o_cmd.op = in_range ? OP_READ : OP_NOP;
            default:    o_cmd.op = OP_NOP;
        endcase
    end

endmodule

// ===== hdl/tcw_cmd_fifo.sv =====
// ============================================================================
// tcw_cmd_fifo - two-entry command queue
// Decouples the classifier from the sequencer so that each can stall alone.
// ============================================================================
module tcw_cmd_fifo
    import tcw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);
    localparam int CNTW  = $clog2(DEPTH + 1);

    t_cmd            r_slot [DEPTH];
    logic [PW-1:0]   r_wp, n_wp;
    logic [PW-1:0]   r_rp, n_rp;
    logic [CNTW-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CNTW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_slot[r_rp];

    always_comb begin
        n_wp  = i_push ? r_wp + 1'b1 : r_wp;
        n_rp  = i_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

endmodule

// ===== hdl/tcw_back.sv =====
// ============================================================================
// tcw_back - cell buffer and command sequencer
// Holds the screen memory and the cursor, carries out one command at a time
// (cell writes, tab runs, scroll copy, blanking sweeps, reads) and keeps the
// registered result until the receiver takes it.
// ============================================================================
module tcw_back
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [7:0]    i_attr,
    input  logic          i_cmd_valid,
    input  t_cmd          i_cmd,
    output logic          o_pop,
    output logic          o_init_busy,
    tcw_out_if.source     o_out
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);

    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
    localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);

    localparam logic [3:0] ST_INIT   = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_ADDR   = 4'd2;
    localparam logic [3:0] ST_WRITE  = 4'd3;
    localparam logic [3:0] ST_RDWAIT = 4'd4;
    localparam logic [3:0] ST_RDCAP  = 4'd5;
    localparam logic [3:0] ST_CLEAR  = 4'd6;
    localparam logic [3:0] ST_SCROLL = 4'd7;
    localparam logic [3:0] ST_TAIL   = 4'd8;
    localparam logic [3:0] ST_BLANK  = 4'd9;
    localparam logic [3:0] ST_DONE   = 4'd10;

    logic [CELL_W-1:0] r_mem [CELLS];
    logic [CELL_W-1:0] r_rdata;

    logic [3:0]        r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [RW-1:0]     r_row, n_row;
    logic [CW-1:0]     r_col, n_col;
    logic [AW-1:0]     r_addr, n_addr;
    logic [AW-1:0]     r_src, n_src;
    logic              r_pend, n_pend;
    logic              r_scr, n_scr;
    logic [CELL_W-1:0] r_res_data, n_res_data;
    logic              r_ovalid, n_ovalid;
    logic [CELL_W-1:0] r_o_data, n_o_data;
    logic [ROW_W-1:0]  r_o_row, n_o_row;
    logic [COL_W-1:0]  r_o_col, n_o_col;
    logic              r_o_scr, n_o_scr;

    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    logic [CELL_W-1:0] mem_wd;
    logic [AW-1:0]     rd_addr;
    logic              wrap;
    logic [CW-1:0]     col_next;
    logic              out_free;

    assign o_init_busy         = (r_state == ST_INIT);
    assign o_out.valid         = r_ovalid;
    assign o_out.cell_data     = r_o_data;
    assign o_out.cursor_row    = r_o_row;
    assign o_out.cursor_column = r_o_col;
    assign o_out.scrolled      = r_o_scr;

    assign wrap     = (r_col == LAST_COL);
    assign col_next = wrap ? '0 : r_col + 1'b1;
    assign out_free = !r_ovalid || o_out.ready;

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_row      = r_row;
        n_col      = r_col;
        n_addr     = r_addr;
        n_src      = r_src;
        n_pend     = r_pend;
        n_scr      = r_scr;
        n_res_data = r_res_data;
        n_ovalid   = r_ovalid && !o_out.ready;
        n_o_data   = r_o_data;
        n_o_row    = r_o_row;
        n_o_col    = r_o_col;
        n_o_scr    = r_o_scr;
        o_pop      = 1'b0;
        mem_we     = 1'b0;
        mem_wa     = r_addr;
        mem_wd     = {i_attr, CHAR_SPACE};
        rd_addr    = r_addr;

        unique case (r_state)
            ST_INIT: begin
                // Power-up blanking always uses the reset attribute.
                mem_we = 1'b1;
                mem_wd = {ATTR_RESET, CHAR_SPACE};
                if (r_addr == LAST_CELL) begin
                    n_addr  = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop      = 1'b1;
                    n_cmd      = i_cmd;
                    n_scr      = 1'b0;
                    n_res_data = '0;
                    unique case (i_cmd.op)
                        OP_PUT, OP_TAB, OP_READ: n_state = ST_ADDR;
                        OP_NEWLINE: begin
                            n_col = '0;
                            if (r_row == LAST_ROW) begin
                                n_scr   = 1'b1;
                                n_addr  = '0;
                                n_src   = COLS_A;
                                n_pend  = 1'b0;
                                n_state = ST_SCROLL;
                            end else begin
                                n_row   = r_row + 1'b1;
                                n_state = ST_DONE;
                            end
                        end
                        OP_RETURN: begin
                            n_col   = '0;
                            n_state = ST_DONE;
                        end
                        OP_CLEAR: begin
                            n_row   = '0;
                            n_col   = '0;
                            n_addr  = '0;
                            n_state = ST_CLEAR;
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_ADDR: begin
                if (r_cmd.op == OP_READ) begin
                    n_addr  = AW'(r_cmd.row) * COLS_A + AW'(r_cmd.col);
                    n_state = ST_RDWAIT;
                end else begin
                    n_addr  = AW'(r_row) * COLS_A + AW'(r_col);
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                mem_we = 1'b1;
                mem_wd = {i_attr, (r_cmd.op == OP_TAB) ? CHAR_SPACE : r_cmd.ch};
                n_col  = col_next;
                if (wrap && (r_row == LAST_ROW)) begin
                    // A wrap leaves the column at zero, so a tab run ends here too.
                    n_scr   = 1'b1;
                    n_addr  = '0;
                    n_src   = COLS_A;
                    n_pend  = 1'b0;
                    n_state = ST_SCROLL;
                end else begin
                    if (wrap) begin
                        n_row = r_row + 1'b1;
                    end
                    if ((r_cmd.op == OP_TAB) && ((col_next[1:0] & TAB_MASK) != 2'b00)) begin
                        n_state = ST_ADDR;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_RDWAIT: n_state = ST_RDCAP;
            ST_RDCAP: begin
                n_res_data = r_rdata;
                n_state    = ST_DONE;
            end
            ST_CLEAR: begin
                mem_we = 1'b1;
                if (r_addr == LAST_CELL) begin
                    n_state = ST_DONE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            ST_SCROLL: begin
                // Read one row ahead and write the cell fetched in the cycle before.
                rd_addr = r_src;
                if (r_pend) begin
                    mem_we = 1'b1;
                    mem_wd = r_rdata;
                    n_addr = r_addr + 1'b1;
                end
                if (r_src == LAST_CELL) begin
                    n_state = ST_TAIL;
                end else begin
                    n_src  = r_src + 1'b1;
                    n_pend = 1'b1;
                end
            end
            ST_TAIL: begin
                mem_we  = 1'b1;
                mem_wd  = r_rdata;
                n_addr  = r_addr + 1'b1;
                n_state = ST_BLANK;
            end
            ST_BLANK: begin
                mem_we = 1'b1;
                if (r_addr == LAST_CELL) begin
                    n_state = ST_DONE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_o_data = r_res_data;
                    n_o_row  = ROW_W'(r_row);
                    n_o_col  = COL_W'(r_col);
                    n_o_scr  = r_scr;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_INIT;
            r_addr   <= '0;
            r_row    <= '0;
            r_col    <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_row    <= n_row;
            r_col    <= n_col;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_src      <= n_src;
        r_scr      <= n_scr;
        r_res_data <= n_res_data;
        r_o_data   <= n_o_data;
        r_o_row    <= n_o_row;
        r_o_col    <= n_o_col;
        r_o_scr    <= n_o_scr;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[rd_addr];
    end

endmodule

// ===== hdl/text_console_writer.sv =====
// ============================================================================
// text_console_writer - character-cell text console
// Requests arrive on i_in (mode, character, read position) and every request
// returns exactly one result on o_out (cell data, cursor, scroll flag).
// The user must write the attribute byte through i_cfg_we / i_cfg_wdata
// only while idle; the block itself does not enforce this. A classifier feeds
// a two-entry command queue; a sequencer drives a single-port-write,
// registered-read cell memory of ROWS*COLUMNS entries and finishes each
// request before it takes the next one from the queue. A scroll is a
// pipelined row copy, then bottom-row blanking, and a clear writes every
// cell, one memory write per cycle. After reset the memory is blanked in
// one pass during which i_in.ready is low. A stalled receiver holds the
// result in the output register; the sequencer still finishes one further
// request and two more queue before i_in.ready drops.
// ============================================================================
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    tcw_in_if.sink     i_in,
    tcw_out_if.source  o_out
);

    logic [7:0] r_attribute;
    logic       init_busy;
    logic       fifo_full;
    logic       fifo_valid;
    logic       cmd_push;
    logic       cmd_pop;
    t_cmd       front_cmd;
    t_cmd       queue_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attribute <= ATTR_RESET;
        end else if (i_cfg_we) begin
            r_attribute <= i_cfg_wdata;
        end
    end

    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_enable (!init_busy),
        .i_full   (fifo_full),
        .i_in     (i_in),
        .o_push   (cmd_push),
        .o_cmd    (front_cmd)
    );

    tcw_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (front_cmd),
        .i_pop   (cmd_pop),
        .o_full  (fifo_full),
        .o_valid (fifo_valid),
        .o_cmd   (queue_cmd)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_attr      (r_attribute),
        .i_cmd_valid (fifo_valid),
        .i_cmd       (queue_cmd),
        .o_pop       (cmd_pop),
        .o_init_busy (init_busy),
        .o_out       (o_out)
    );

    // No request may enter while the power-up blanking pass runs.
    a_no_accept_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        init_busy |-> !i_in.ready)
        else $error("request accepted during power-up blanking");

    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_full |-> !cmd_push)
        else $error("command pushed into a full queue");

    a_attr_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_attribute == $past(i_cfg_wdata)))
        else $error("attribute register not updated by write");

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((int'(o_out.cursor_row) < ROWS)
                         && (int'(o_out.cursor_column) < COLUMNS)))
        else $error("reported cursor lies outside the screen");

endmodule
